// ----- hdl/bwo_pkg.sv -----
// shared types and constants of the band-limited waveform oscillator
`default_nettype none
package bwo_pkg;

	localparam logic [2:0] WAVE_SINE     = 3'd0;
	localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
	localparam logic [2:0] WAVE_SAW      = 3'd2;
	localparam logic [2:0] WAVE_SQUARE   = 3'd3;
	localparam logic [2:0] WAVE_PULSE    = 3'd4;

	localparam logic [2:0] REG_WAVEFORM  = 3'd0;
	localparam logic [2:0] REG_INCREMENT = 3'd1;
	localparam logic [2:0] REG_OFFSET    = 3'd2;
	localparam logic [2:0] REG_WIDTH     = 3'd3;
	localparam logic [2:0] REG_BL_ENABLE = 3'd4;

	localparam longint unsigned PIHALF_Q30 = 64'd1686629713;
	localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
	localparam logic signed [35:0] Q28_ONE = 36'sd268435456;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BASE,
		ST_SIN_MUL,
		ST_SIN_ADA,
		ST_SIN_ADB,
		ST_SIN_INT,
		ST_SIN_FIN,
		ST_C_CHK,
		ST_C_DIV,
		ST_C_SQ,
		ST_C_P1,
		ST_C_P2,
		ST_C_P3,
		ST_C_P4,
		ST_C_NEXT,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

// ----- hdl/bwo_div.sv -----
// restoring divider, one quotient bit per cycle, num <= 2*den assumed
`default_nettype none
module bwo_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] num,
	input  wire logic [31:0] den,
	output logic             done,
	output logic [30:0]      quo
);
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [30:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [33:0] diff;
	logic        ge;

	always_comb begin
		trial = (cnt_q == 5'd0) ? {1'b0, rem_q} : {rem_q, 1'b0};
		diff  = {1'b0, trial} - {2'b00, den_q};
		ge    = !diff[33];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd30) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[29:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// ----- hdl/bwo_sine_rom.sv -----
// quarter-wave sine table built at elaboration, registered read
`default_nettype none
module bwo_sine_rom #(
	parameter int DEPTH = 256
) (
	input  wire logic                         clk,
	input  wire logic [$clog2(DEPTH+1)-1:0]   addr,
	output logic      [28:0]                  data
);
	import bwo_pkg::*;

	logic [28:0] tab [DEPTH+1];
	logic [28:0] data_q;

	for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
		localparam longint unsigned X =
			(PIHALF_Q30 * longint'(k) + longint'(DEPTH / 2)) / longint'(DEPTH);
		localparam longint unsigned X2 = (X * X + 64'd536870912) >> 30;
		localparam longint unsigned T1  = ((X   * X2) >> 30) / 6;
		localparam longint unsigned T2  = ((T1  * X2) >> 30) / 20;
		localparam longint unsigned T3  = ((T2  * X2) >> 30) / 42;
		localparam longint unsigned T4  = ((T3  * X2) >> 30) / 72;
		localparam longint unsigned T5  = ((T4  * X2) >> 30) / 110;
		localparam longint unsigned T6  = ((T5  * X2) >> 30) / 156;
		localparam longint unsigned T7  = ((T6  * X2) >> 30) / 210;
		localparam longint unsigned T8  = ((T7  * X2) >> 30) / 272;
		localparam longint unsigned T9  = ((T8  * X2) >> 30) / 342;
		localparam longint unsigned T10 = ((T9  * X2) >> 30) / 420;
		localparam longint unsigned T11 = ((T10 * X2) >> 30) / 506;
		localparam longint unsigned T12 = ((T11 * X2) >> 30) / 600;
		localparam longint S = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
			+ longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7) + longint'(T8)
			- longint'(T9) + longint'(T10) - longint'(T11) + longint'(T12);
		localparam longint SP = (S < 0) ? 64'sd0 : S;
		localparam longint SR = (SP + 2) / 4;
		localparam longint SC = (SR > 64'sd268435456) ? 64'sd268435456 : SR;
		assign tab[k] = 29'(SC);
	end

	always_ff @(posedge clk) begin
		data_q <= tab[addr];
	end

	assign data = data_q;
endmodule
`default_nettype wire

// ----- hdl/bandlimited_waveform_oscillator.sv -----
// top level: phase accumulator oscillator with shared multiplier and divider
// Input channel s_*: one transaction per sample; s_tdata[0] is the restart
// flag, which reloads the phase from phase_offset before the sample is made.
// Output channel m_*: one signed Q3.28 sample per input transaction, in order.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 waveform,
// 1 phase_increment, 2 phase_offset which also loads the phase, 3 pulse_width,
// 4 bandlimit_enable); the user must write only while the block is idle;
// the block itself does not enforce this. With correction a polyBLEP edge
// (saw, square, pulse) or a BLAMP corner (triangle) is corrected inside its
// window; an edge or corner outside its window is passed over. A corrected
// saw has one jump, a square or pulse two jumps and a triangle two corners.
// The shared restoring divider that forms the edge ratio dominates; the shared
// 32x32 multiplier registers each product. One sample is worked on at a
// time; s_tready is high only between samples.
// The result sits in an output register, so a new input is taken while the
// previous sample waits; a stalled receiver holds the engine at its last
// step until the register frees up.
// Reset clears the phase to zero and loads the register reset values.
`default_nettype none
module bandlimited_waveform_oscillator #(
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] sample
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import bwo_pkg::*;

	localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SINE_TABLE_DEPTH);

	state_t state_q, state_d;

	logic [2:0]  waveform_q;
	logic [31:0] inc_q, offset_q, width_q, phase_q, p_q;
	logic        bl_q;
	logic signed [35:0] acc_q;
	logic        corr_q, br_q;
	logic [63:0] prod_q;
	logic [31:0] mul_a, mul_b;
	logic [IW-1:0] rom_addr, idx_q;
	logic [28:0] rom_data, a_q;
	logic [29:0] frac_q;
	logic        ge_q;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_free;

	logic        div_start, div_done;
	logic [30:0] div_quo;

	logic [31:0] p_in, t, tsum_lo, sin_r32;
	logic [32:0] tsum;
	logic        before_edge, after_edge, is_blep, neg;
	logic [31:0] tri_u, tri_d;
	logic signed [35:0] base, blep_term, blamp_term, sine_val, sat_in;
	logic [29:0] sq;
	logic [32:0] cval;
	logic [28:0] absdiff, delta;
	logic signed [30:0] mag;
	logic [31:0] sat_out;

	bwo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (after_edge ? (inc_q - t) : tsum_lo),
		.den    (inc_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	bwo_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	assign out_free = !out_valid_q || m_tready;
	assign p_in     = s_tdata[0] ? offset_q : phase_q;

	// edge windows, naive shapes, correction terms, sine interpolation and saturation
	always_comb begin
		unique case (waveform_q)
			WAVE_TRIANGLE: t = corr_q ? (p_q + 32'hC000_0000) : (p_q + 32'h4000_0000);
			WAVE_SQUARE:   t = corr_q ? (p_q + 32'h8000_0000) : p_q;
			WAVE_PULSE:    t = corr_q ? (p_q - width_q) : p_q;
			default:       t = p_q;
		endcase
		tsum        = {1'b0, t} + {1'b0, inc_q};
		tsum_lo     = tsum[31:0];
		after_edge  = t < inc_q;
		before_edge = tsum[32] && (tsum_lo != 32'd0);
		is_blep     = waveform_q != WAVE_TRIANGLE;
		neg         = corr_q || (waveform_q == WAVE_SAW);

		tri_u = p_q + 32'h4000_0000;
		tri_d = tri_u[31] ? (tri_u - 32'h8000_0000) : (32'h8000_0000 - tri_u);
		unique case (waveform_q)
			WAVE_TRIANGLE: base = Q28_ONE - $signed({6'd0, tri_d[31:2]});
			WAVE_SAW:      base = $signed({7'd0, p_q[31:3]}) - Q28_ONE;
			WAVE_SQUARE:   base = p_q[31] ? -Q28_ONE : Q28_ONE;
			WAVE_PULSE:    base = (p_q < width_q) ? Q28_ONE : -Q28_ONE;
			default:       base = '0;
		endcase

		sin_r32 = p_q[30] ? (32'h4000_0000 - {2'b00, p_q[29:0]}) : {2'b00, p_q[29:0]};

		sq        = 30'((prod_q + 64'h8000_0000) >> 32);
		blep_term = (br_q ^ neg) ? -$signed({6'd0, sq}) : $signed({6'd0, sq});
		cval      = prod_q[62:30];
		blamp_term = neg ? -$signed({3'd0, cval}) : $signed({3'd0, cval});

		absdiff = (rom_data >= a_q) ? (rom_data - a_q) : (a_q - rom_data);
		delta   = prod_q[58:30];
		mag     = ge_q ? $signed({2'b00, a_q} + {2'b00, delta})
		               : $signed({2'b00, a_q} - {2'b00, delta});
		sine_val = p_q[31] ? -36'(mag) : 36'(mag);

		sat_in = acc_q;
		if (sat_in > 36'sd2147483647)       sat_out = 32'h7FFF_FFFF;
		else if (sat_in < -36'sd2147483648) sat_out = 32'h8000_0000;
		else                                sat_out = sat_in[31:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (s_tvalid) state_d = ST_BASE;
			ST_BASE: begin
				if (waveform_q == WAVE_SINE) state_d = ST_SIN_MUL;
				else if (bl_q && (waveform_q == WAVE_TRIANGLE || waveform_q == WAVE_SAW
					|| waveform_q == WAVE_SQUARE || waveform_q == WAVE_PULSE))
					state_d = ST_C_CHK;
				else state_d = ST_FIN;
			end
			ST_SIN_MUL: state_d = ST_SIN_ADA;
			ST_SIN_ADA: state_d = ST_SIN_ADB;
			ST_SIN_ADB: state_d = ST_SIN_INT;
			ST_SIN_INT: state_d = ST_SIN_FIN;
			ST_SIN_FIN: state_d = ST_FIN;
			ST_C_CHK:   state_d = (after_edge || before_edge) ? ST_C_DIV : ST_C_NEXT;
			ST_C_DIV:   if (div_done) state_d = ST_C_SQ;
			ST_C_SQ:    state_d = ST_C_P1;
			ST_C_P1:    state_d = is_blep ? ST_C_NEXT : ST_C_P2;
			ST_C_P2:    state_d = ST_C_P3;
			ST_C_P3:    state_d = ST_C_P4;
			ST_C_P4:    state_d = ST_C_NEXT;
			ST_C_NEXT:  state_d = (corr_q || waveform_q == WAVE_SAW) ? ST_FIN : ST_C_CHK;
			ST_FIN:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		rom_addr  = idx_q;
		unique case (state_q)
			ST_IDLE:    s_tready = 1'b1;
			ST_SIN_MUL: begin
				mul_a = sin_r32;
				mul_b = 32'(SINE_TABLE_DEPTH);
			end
			ST_SIN_ADA: begin
				rom_addr = (prod_q[30+IW-1:30] >= LAST_IDX) ? LAST_IDX : prod_q[30+IW-1:30];
			end
			ST_SIN_ADB: rom_addr = (idx_q >= LAST_IDX) ? LAST_IDX : idx_q + IW'(1);
			ST_SIN_INT: begin
				mul_a = {3'd0, absdiff};
				mul_b = {2'd0, frac_q};
			end
			ST_C_CHK:   div_start = after_edge || before_edge;
			ST_C_SQ: begin
				mul_a = {1'b0, div_quo};
				mul_b = {1'b0, div_quo};
			end
			ST_C_P1: begin
				mul_a = prod_q[61:30];
				mul_b = {1'b0, div_quo};
			end
			ST_C_P2: begin
				mul_a = prod_q[61:30];
				mul_b = RECIP3;
			end
			ST_C_P3: begin
				mul_a = inc_q;
				mul_b = prod_q[64-1:33] & 32'h7FFF_FFFF;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			waveform_q  <= WAVE_SINE;
			inc_q       <= '0;
			offset_q    <= '0;
			width_q     <= 32'h8000_0000;
			bl_q        <= 1'b1;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
			corr_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WAVEFORM:  waveform_q <= cfg_data[2:0];
					REG_INCREMENT: inc_q <= cfg_data;
					REG_OFFSET: begin
						offset_q <= cfg_data;
						phase_q  <= cfg_data;
					end
					REG_WIDTH:     width_q <= cfg_data;
					REG_BL_ENABLE: bl_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == ST_IDLE && s_tvalid) phase_q <= p_in + inc_q;
			if (state_q == ST_BASE) corr_q <= 1'b0;
			if (state_q == ST_C_NEXT) corr_q <= 1'b1;
			if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE:    p_q <= p_in;
			ST_BASE:    acc_q <= base;
			ST_SIN_ADA: begin
				idx_q  <= prod_q[30+IW-1:30];
				frac_q <= prod_q[29:0];
			end
			ST_SIN_ADB: a_q <= rom_data;
			ST_SIN_INT: ge_q <= rom_data >= a_q;
			ST_SIN_FIN: acc_q <= sine_val;
			ST_C_CHK:   br_q <= after_edge;
			ST_C_P1:    if (is_blep) acc_q <= acc_q + blep_term;
			ST_C_P4:    acc_q <= acc_q + blamp_term;
			ST_FIN:     if (out_free) out_data_q <= sat_out;
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
endmodule
`default_nettype wire
